// ===== sv/fsos_pkg.sv =====
package fsos_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_WB,
    ST_OUT
  } state_t;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic REG_SCALE_LIMIT = 1'b0;

  localparam logic [31:0] SCALE_LIMIT_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_RESET         = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_RESET         = 32'h8000_0000;
  localparam logic [31:0] MOST_NEGATIVE     = 32'h8000_0000;
  localparam logic [31:0] MOST_POSITIVE     = 32'h7FFF_FFFF;

  localparam int ENTRY_W = 160;

endpackage

// ===== sv/fsos_in_if.sv =====
interface fsos_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [5:0]         feature_index;
  logic signed [31:0] sample_value;
  logic               last_of_sample;
  logic               fixed_kind;
  logic signed [31:0] prior_offset;
  logic [31:0]        prior_scale;

  modport source (output valid, op, feature_index, sample_value, last_of_sample,
                  fixed_kind, prior_offset, prior_scale, input ready);
  modport sink (input valid, op, feature_index, sample_value, last_of_sample,
                fixed_kind, prior_offset, prior_scale, output ready);
endinterface

// ===== sv/fsos_out_if.sv =====
interface fsos_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         result_index;
  logic signed [31:0] offset;
  logic [31:0]        scale;

  modport source (output valid, result_index, offset, scale, input ready);
  modport sink (input valid, result_index, offset, scale, output ready);
endinterface

// ===== sv/feature_stats_offset_scale.sv =====
// Per-feature running statistics with offset and scale query. An update item
// folds one sample element into the minimum, maximum, mean and mean of
// squares of its feature and gives no result; the shared sample count
// advances (saturating) after an element marked last. A query item gives one
// result: the prior values for a fixed feature, zero and zero where min equals
// max or the index is out of range, else the negated mean and
// floor(2^32/sqrt(variance)) clamped to scale_limit (scale_limit when the
// variance is one or less). Items are handled one at a time. The per-feature
// statistics live in a single 160-bit wide memory, read, modified and written
// back. After reset a clearing pass writes the reset values into every entry;
// no item is accepted meanwhile. An update waits on the 65-step divider that
// divides by the count; a query that needs the square root runs 65 divider
// steps then 32 root steps; other queries skip the divider and the root. A
// finished result waits in the output register while the next item is taken.
module feature_stats_offset_scale #(
  parameter int FEATURES = 64
) (
  input  logic        clk,
  input  logic        rst,
  fsos_in_if.sink     items,
  fsos_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  fsos_pkg::state_t state, state_next;

  logic [AW-1:0] clr_addr;
  logic [31:0]   scale_limit;
  logic [31:0]   sample_count;

  // latched item
  logic               op_r;
  logic [5:0]         idx_r;
  logic signed [31:0] x_r;
  logic               fixed_r;
  logic signed [31:0] poff_r;
  logic [31:0]        psc_r;
  logic               in_range_r;
  logic [32:0]        n1_r;

  // entry read back
  logic signed [31:0] min_r, max_r, mean_r;
  logic [63:0]        msq_r;
  logic signed [63:0] prod_r;
  logic               neg_m_r, neg_s_r;

  logic signed [31:0] res_off;
  logic [31:0]        res_sc;

  // output register
  logic               out_valid;
  logic [5:0]         out_idx;
  logic signed [31:0] out_off;
  logic [31:0]        out_sc;

  // memory
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [fsos_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;

  logic               accept;
  logic               cfg_write;
  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p;
  logic signed [32:0] diff_m;
  logic [32:0]        mag_m;
  logic signed [64:0] diff_s;
  logic [64:0]        neg_diff_s;
  logic [63:0]        mag_s;
  logic signed [63:0] var_v;
  logic               var_small;
  logic               quick;
  logic               div_start;
  logic [64:0]        big_num;
  logic [63:0]        big_den;
  logic               big_busy, small_busy;
  logic [64:0]        big_quo;
  logic [32:0]        small_quo;
  logic               sq_start, sq_busy;
  logic [31:0]        sq_root;
  logic [32:0]        q_m;
  logic [63:0]        q_s;
  logic signed [31:0] mean_new, min_new, max_new;
  logic [63:0]        msq_new;
  logic signed [31:0] off_calc;
  logic               slot_free;

  assign accept    = items.valid && items.ready;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == fsos_pkg::REG_SCALE_LIMIT) ? scale_limit : '0;
  assign slot_free = !out_valid || results.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_limit <= fsos_pkg::SCALE_LIMIT_RESET;
    end else if (cfg_write && paddr[2] == fsos_pkg::REG_SCALE_LIMIT) begin
      scale_limit <= pwdata;
    end
  end

  fsos_ram #(.WIDTH(fsos_pkg::ENTRY_W), .DEPTH(FEATURES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  // one shared multiplier: x*x for an update, mean*mean for a query
  assign mul_a = (op_r == fsos_pkg::OP_UPDATE) ? x_r : $signed(ram_rdata[95:64]);
  assign mul_p = mul_a * mul_a;

  // differences to divide by the count
  assign diff_m     = {x_r[31], x_r} - {mean_r[31], mean_r};
  assign mag_m      = diff_m[32] ? 33'(-diff_m) : 33'(diff_m);
  assign diff_s     = {1'b0, prod_r} - {1'b0, msq_r};
  assign neg_diff_s = 65'(-diff_s);
  assign mag_s      = diff_s[64] ? neg_diff_s[63:0] : diff_s[63:0];

  assign var_v     = $signed(msq_r) - prod_r;
  assign var_small = (var_v <= 64'sd1);
  assign quick     = fixed_r || !in_range_r || (min_r == max_r);
  assign off_calc  = (mean_r == $signed(fsos_pkg::MOST_NEGATIVE)) ?
                     $signed(fsos_pkg::MOST_POSITIVE) : -mean_r;

  assign div_start = (state == fsos_pkg::ST_PREP) &&
                     (((op_r == fsos_pkg::OP_UPDATE) && in_range_r) ||
                      ((op_r == fsos_pkg::OP_QUERY) && !quick && !var_small));
  assign big_num   = (op_r == fsos_pkg::OP_UPDATE) ? {1'b0, mag_s} : {1'b1, 64'b0};
  assign big_den   = (op_r == fsos_pkg::OP_UPDATE) ? {31'b0, n1_r} : var_v;

  // 2^64 / variance for a query, mean of squares step for an update
  fsos_div #(.NW(65), .DW(64)) u_div_wide (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (big_num),
    .den   (big_den),
    .busy  (big_busy),
    .quo   (big_quo)
  );

  fsos_div #(.NW(33), .DW(33)) u_div_mean (
    .clk   (clk),
    .rst   (rst),
    .start (div_start && (op_r == fsos_pkg::OP_UPDATE)),
    .num   (mag_m),
    .den   (n1_r),
    .busy  (small_busy),
    .quo   (small_quo)
  );

  assign sq_start = (state == fsos_pkg::ST_DIV) && (op_r == fsos_pkg::OP_QUERY) && !big_busy;

  fsos_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v     (big_quo[63:0]),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // write-back values
  assign q_m      = neg_m_r ? 33'(-small_quo) : small_quo;
  assign q_s      = neg_s_r ? 64'(-big_quo[63:0]) : big_quo[63:0];
  assign mean_new = mean_r + $signed(q_m[31:0]);
  assign msq_new  = msq_r + q_s;
  assign min_new  = (x_r < min_r) ? x_r : min_r;
  assign max_new  = (x_r > max_r) ? x_r : max_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fsos_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(FEATURES - 1)) state_next = fsos_pkg::ST_IDLE;
      end
      fsos_pkg::ST_IDLE: begin
        if (items.valid) state_next = fsos_pkg::ST_READ;
      end
      fsos_pkg::ST_READ: state_next = fsos_pkg::ST_LOAD;
      fsos_pkg::ST_LOAD: state_next = fsos_pkg::ST_PREP;
      fsos_pkg::ST_PREP: begin
        if (op_r == fsos_pkg::OP_UPDATE) begin
          state_next = in_range_r ? fsos_pkg::ST_DIV : fsos_pkg::ST_IDLE;
        end else begin
          state_next = (quick || var_small) ? fsos_pkg::ST_OUT : fsos_pkg::ST_DIV;
        end
      end
      fsos_pkg::ST_DIV: begin
        if (!big_busy && !small_busy) begin
          state_next = (op_r == fsos_pkg::OP_UPDATE) ? fsos_pkg::ST_WB : fsos_pkg::ST_SQRT;
        end
      end
      fsos_pkg::ST_SQRT: begin
        if (!sq_busy) state_next = fsos_pkg::ST_OUT;
      end
      fsos_pkg::ST_WB: state_next = fsos_pkg::ST_IDLE;
      fsos_pkg::ST_OUT: begin
        if (slot_free) state_next = fsos_pkg::ST_IDLE;
      end
      default: state_next = fsos_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    items.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx_r);
    ram_wdata   = {min_new, max_new, mean_new, msq_new};
    case (state)
      fsos_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = {fsos_pkg::MIN_RESET, fsos_pkg::MAX_RESET, 32'b0, 64'b0};
      end
      fsos_pkg::ST_IDLE: items.ready = 1'b1;
      fsos_pkg::ST_WB:   ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fsos_pkg::ST_CLEAR;
      clr_addr     <= '0;
      sample_count <= '0;
    end else begin
      state <= state_next;
      if (state == fsos_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      // the count moves at once; this item divides by the old count plus one
      if (accept && items.op == fsos_pkg::OP_UPDATE && items.last_of_sample &&
          sample_count != fsos_pkg::COUNT_MAX) begin
        sample_count <= sample_count + 32'd1;
      end
    end
  end

  // item and entry registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= items.op;
      idx_r      <= items.feature_index;
      x_r        <= items.sample_value;
      fixed_r    <= items.fixed_kind;
      poff_r     <= items.prior_offset;
      psc_r      <= items.prior_scale;
      in_range_r <= (32'(items.feature_index) < 32'(FEATURES));
      n1_r       <= {1'b0, sample_count} + 33'd1;
    end
    if (state == fsos_pkg::ST_LOAD) begin
      min_r  <= $signed(ram_rdata[159:128]);
      max_r  <= $signed(ram_rdata[127:96]);
      mean_r <= $signed(ram_rdata[95:64]);
      msq_r  <= ram_rdata[63:0];
      prod_r <= mul_p;
    end
    if (state == fsos_pkg::ST_PREP) begin
      neg_m_r <= diff_m[32];
      neg_s_r <= diff_s[64];
      if (fixed_r) begin
        res_off <= poff_r;
        res_sc  <= psc_r;
      end else if (!in_range_r || min_r == max_r) begin
        res_off <= '0;
        res_sc  <= '0;
      end else begin
        res_off <= off_calc;
        res_sc  <= scale_limit;
      end
    end
    if (state == fsos_pkg::ST_SQRT && !sq_busy) begin
      res_sc <= (sq_root < scale_limit) ? sq_root : scale_limit;
    end
  end

  // output register: hold a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fsos_pkg::ST_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fsos_pkg::ST_OUT && slot_free) begin
      out_idx <= idx_r;
      out_off <= res_off;
      out_sc  <= res_sc;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_index = out_idx;
  assign results.offset       = out_off;
  assign results.scale        = out_sc;

endmodule

// ===== sv/fsos_ram.sv =====
module fsos_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/fsos_div.sv =====
module fsos_div #(
  parameter int NW = 65,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, acc[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});
  assign quo   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CW'(NW);
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      acc <= {acc[NW-2:0], fits};
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== sv/fsos_isqrt.sv =====
module fsos_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] val;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] sum;

  // two radicand bits per cycle
  assign sum  = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      val  <= v;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (val >= sum) begin
        val <= val - sum;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      busy <= (bitv[63:2] != '0);
    end
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One item as offered on the input channel
  typedef struct {
    logic               op;
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic               last;
    logic               fixed;
    logic signed [31:0] poff;
    logic [31:0]        psc;
  } norm_item_t;

  // One normalisation result: index, offset and scale
  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] off;
    logic [31:0]        sc;
  } norm_result_t;

  // Directed row: an item, plus a hand-written result where one is obvious
  typedef struct {
    norm_item_t   item;
    bit           typed;
    norm_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fsos_in_if  in_if();
  fsos_out_if out_if();

  feature_stats_offset_scale dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_if.sink),
    .results (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor's copy of the statistics, the shared count and the clamp
  logic signed [31:0] stat_min  [64];
  logic signed [31:0] stat_max  [64];
  logic signed [31:0] stat_mean [64];
  logic [63:0]        stat_msq  [64];
  logic [31:0]        sample_cnt;
  logic [31:0]        scale_cap;

  norm_result_t  pending_results[$];
  directed_row_t rows[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A generous ceiling on the length of the whole run
  initial begin
    #8_000_000;
    $display("** feature_stats_offset_scale: FAILED **");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch %s: expected %h, got %h", $realtime, what, want, got);
    errors++;
  endtask

  task automatic add_row(input directed_row_t r);
    rows.insert(rows.size(), r);
  endtask

  // floor(2^32/sqrt(v)) as Q16.16, i.e. the largest s with s*s*v <= 2^64
  function automatic logic [31:0] inv_root_q16(logic [63:0] v);
    logic [63:0] q, rem, root, b;
    if (v <= 64'd1) return 32'hFFFF_FFFF;
    q = 64'hFFFF_FFFF_FFFF_FFFF / v;
    if (64'hFFFF_FFFF_FFFF_FFFF % v == v - 64'd1) q = q + 64'd1;
    rem  = q;
    root = '0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < 64; i++) begin
      stat_min[i]  = fsos_pkg::MIN_RESET;
      stat_max[i]  = fsos_pkg::MAX_RESET;
      stat_mean[i] = '0;
      stat_msq[i]  = '0;
    end
    sample_cnt = '0;
    scale_cap  = fsos_pkg::SCALE_LIMIT_RESET;
  endtask

  // Fold an accepted item into the statistics, or work out its result
  task automatic fold_or_normalise(input norm_item_t it, output bit has_res,
                                   output norm_result_t res);
    longint n1, xv, mean, msq, sq, var_q32;
    logic [31:0] s;
    n1 = longint'({32'd0, sample_cnt}) + 1;
    xv = longint'(it.x);
    mean = longint'(stat_mean[it.idx]);
    msq = $signed(stat_msq[it.idx]);
    has_res = 1'b0;
    res = '{idx: it.idx, off: '0, sc: '0};
    if (it.op == fsos_pkg::OP_UPDATE) begin
      sq = xv * xv;
      if (it.x < stat_min[it.idx]) stat_min[it.idx] = it.x;
      if (it.x > stat_max[it.idx]) stat_max[it.idx] = it.x;
      stat_mean[it.idx] = 32'(mean + (xv - mean) / n1);
      stat_msq[it.idx]  = 64'(msq + (sq - msq) / n1);
      if (it.last && sample_cnt != fsos_pkg::COUNT_MAX) sample_cnt = sample_cnt + 1;
      return;
    end
    has_res = 1'b1;
    if (it.fixed) begin
      res.off = it.poff;
      res.sc  = it.psc;
    end else if (stat_min[it.idx] != stat_max[it.idx]) begin
      var_q32 = msq - mean * mean;
      res.off = (stat_mean[it.idx] == fsos_pkg::MOST_NEGATIVE) ?
                fsos_pkg::MOST_POSITIVE : 32'(-mean);
      if (var_q32 <= 0) begin
        res.sc = scale_cap;
      end else begin
        s = inv_root_q16(64'(var_q32));
        res.sc = (s < scale_cap) ? s : scale_cap;
      end
    end
  endtask

  // Offer one item; hold it until the block takes it
  task automatic offer_item(input norm_item_t it, input bit typed, input norm_result_t want);
    bit has_res;
    norm_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid          = 1'b1;
    in_if.op             = it.op;
    in_if.feature_index  = it.idx;
    in_if.sample_value   = it.x;
    in_if.last_of_sample = it.last;
    in_if.fixed_kind     = it.fixed;
    in_if.prior_offset   = it.poff;
    in_if.prior_scale    = it.psc;
    do @(posedge clk); while (!in_if.ready);
    fold_or_normalise(it, has_res, res);
    if (has_res) pending_results.insert(pending_results.size(), typed ? want : res);
  endtask

  // Drop valid, wait for every expected result, then let an update finish
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_scale_limit(logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'({fsos_pkg::REG_SCALE_LIMIT, 2'b00});
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    scale_cap = v;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
      2: return 32'($signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000);
      3: return ($urandom_range(0, 1) != 0) ? fsos_pkg::MOST_NEGATIVE :
                                                fsos_pkg::MOST_POSITIVE;
      default: return 32'($signed($urandom_range(0, 32'h6_0000)) + 32'sh1_0000);
    endcase
  endfunction

  function automatic norm_item_t random_item();
    norm_item_t it;
    it.op    = ($urandom_range(0, 99) < 60) ? fsos_pkg::OP_UPDATE : fsos_pkg::OP_QUERY;
    // Keep most traffic on a few features so their statistics build up
    it.idx   = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    it.x     = pick_sample();
    it.last  = ($urandom_range(0, 99) < 30);
    it.fixed = ($urandom_range(0, 99) < 20);
    it.poff  = $urandom;
    it.psc   = $urandom;
    return it;
  endfunction

  // Receiver: random stalls, plus a long hold when the stimulus asks for one
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result taken with the oldest one waiting
  always @(posedge clk) begin
    norm_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result_index", 32'd0, 32'(out_if.result_index));
      end else begin
        want = pending_results.pop_front();
        if (out_if.result_index !== want.idx)
          report_mismatch("result_index", 32'(want.idx), 32'(out_if.result_index));
        if (out_if.offset !== want.off) report_mismatch("offset", want.off, out_if.offset);
        if (out_if.scale !== want.sc) report_mismatch("scale", want.sc, out_if.scale);
      end
    end
  end

  initial begin
    norm_result_t  none;
    int            per_phase;
    in_if.valid = 1'b0;
    in_if.op = fsos_pkg::OP_UPDATE;
    in_if.feature_index = '0;
    in_if.sample_value = '0;
    in_if.last_of_sample = 1'b0;
    in_if.fixed_kind = 1'b0;
    in_if.prior_offset = '0;
    in_if.prior_scale = '0;
    none = '{idx: '0, off: '0, sc: '0};
    clear_stats();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Untouched features: min and max still differ, so offset 0, scale at the cap
    add_row('{'{fsos_pkg::OP_QUERY, 6'd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b1, '{6'd0, 32'sd0, 32'hFFFF_FFFF}});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd63, 32'sd0, 1'b0, 1'b0, 32'sd5, 32'd7},
              1'b1, '{6'd63, 32'sd0, 32'hFFFF_FFFF}});
    // Fixed features pass their priors through, extremes included
    add_row('{'{fsos_pkg::OP_QUERY, 6'd9, 32'sd0, 1'b0, 1'b1,
                fsos_pkg::MOST_NEGATIVE, 32'hFFFF_FFFF},
              1'b1, '{6'd9, fsos_pkg::MOST_NEGATIVE, 32'hFFFF_FFFF}});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd10, 32'sd0, 1'b0, 1'b1,
                fsos_pkg::MOST_POSITIVE, 32'd0},
              1'b1, '{6'd10, fsos_pkg::MOST_POSITIVE, 32'd0}});
    // Most negative sample while the count is still zero: mean becomes most negative
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd4, fsos_pkg::MOST_NEGATIVE, 1'b0, 1'b0,
                32'sd0, 32'd0}, 1'b0, none});
    // One sample only: min equals max, so zero and zero
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd1, 32'sh1_0000, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd1, 32'sd0, 1'b0, 1'b0, 32'sd3, 32'd3},
              1'b1, '{6'd1, 32'sd0, 32'd0}});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd1, 32'sh3_0000, 1'b1, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd1, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd2, fsos_pkg::MOST_NEGATIVE, 1'b0, 1'b0,
                32'sd0, 32'd0}, 1'b0, none});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd2, fsos_pkg::MOST_POSITIVE, 1'b1, 1'b0,
                32'sd0, 32'd0}, 1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd2, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    // Nudge the max of feature 4 off its min; the mean stays most negative
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd4, 32'sh8000_0001, 1'b1, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd4, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    // Two samples one apart at a feature whose min and max start apart
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd63, 32'sh2_0000, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd63, 32'sh2_0001, 1'b1, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd63, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd5, -32'sh1_8000, 1'b1, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_UPDATE, 6'd5, 32'sh0_8000, 1'b1, 1'b0, 32'sd0, 32'd0},
              1'b0, none});
    add_row('{'{fsos_pkg::OP_QUERY, 6'd5, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'd0},
              1'b0, none});

    // Walk the table with no idling, the clamp at its reset value
    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].want);
    drain();
    write_scale_limit(fsos_pkg::SCALE_LIMIT_RESET);

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    per_phase = 610;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 32; recv_idle_pct = 54;
          write_scale_limit(32'd0);
        end
        1: begin
          send_idle_pct = 54; recv_idle_pct = 32;
          write_scale_limit($urandom_range(32'h1000, 32'h40_0000));
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_scale_limit(32'h0002_0000);
          // Hold the receiver off for a long stretch so the block backs up
          hold_left = 600;
        end
      endcase
      for (int n = 0; n < per_phase; n++) offer_item(random_item(), 1'b0, none);
      drain();
    end

    if (errors == 0) begin
      $display("** feature_stats_offset_scale: PASSED **");
    end else begin
      $display("** feature_stats_offset_scale: FAILED **");
    end
    $finish;
  end

endmodule
